// File: hw/rtl/gapped_median_step_detector_macros.svh
// Assertion macros for the gapped median step detector.
// Taken in by the checker file; needs nothing else.
`ifndef GAPPED_MEDIAN_STEP_DETECTOR_MACROS_SVH
`define GAPPED_MEDIAN_STEP_DETECTOR_MACROS_SVH

// Same-cycle implication, off while in reset.
`define GMSD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("gmsd check failed");

// Next-cycle implication, off while in reset.
`define GMSD_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("gmsd check failed");

// Next-cycle implication that also holds through reset.
`define GMSD_ASSERT_RAW(lbl, ck, ante, cons) \
    lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
        else $error("gmsd check failed");

`endif

// File: hw/rtl/gmsd_pkg.sv
// Shared types and constants of the gapped median step detector.
// Used by the interfaces and every module; depends on nothing.
package gmsd_pkg;

    localparam int SEEN_W      = 8;
    localparam int VALUE_W     = 32;
    localparam int MED_W       = 33;
    localparam int STEP_W      = 34;
    localparam int WIN_CFG_W   = 6;
    localparam int GAP_CFG_W   = 5;
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int WIN_W       = 7;
    localparam int GAP_W       = 6;
    localparam int SPAN_W      = 7;
    localparam int RING_AW_MAX = 8;
    localparam int POS_W       = 10;
    localparam int JOB_DEPTH   = 4;
    localparam int JOB_PW      = 2;
    localparam int THIRD_SHIFT = 9;

    localparam logic [SEEN_W-1:0]    SEEN_MAX   = 8'd255;
    localparam logic [WIN_CFG_W-1:0] WIN_RESET  = 6'd8;
    localparam logic [GAP_CFG_W-1:0] GAP_RESET  = 5'd2;
    localparam logic [WIN_W-1:0]     WIN_MIN    = 7'd3;
    localparam logic [WIN_W-1:0]     MINP_FLOOR = 7'd3;
    localparam logic [7:0]           THIRD_MUL  = 8'd171;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW = 1'b0,
        REG_GAP    = 1'b1
    } cfg_reg_t;

    // Clamped settings in use
    typedef struct packed {
        logic [WIN_W-1:0] win;
        logic [GAP_W-1:0] gap;
    } cfg_t;

    // Ring write from the front
    typedef struct packed {
        logic                      en;
        logic [RING_AW_MAX-1:0]    addr;
        logic                      ok;
        logic signed [VALUE_W-1:0] value;
    } ring_wr_t;

    // One queued item: newest ring slot, index, first distance, flags
    typedef struct packed {
        logic [RING_AW_MAX-1:0] newest;
        logic [SEEN_W-1:0]      n;
        logic [SPAN_W-1:0]      d;
        logic                   fin;
        logic                   emit;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SETUP,
        BK_LOAD,
        BK_MED_HI,
        BK_MED_LO,
        BK_EMIT
    } back_state_t;

endpackage

// File: hw/rtl/gmsd_if.sv
// Channel interfaces: sample input, result output, configuration write.
// Depends on gmsd_pkg.
interface gmsd_sample_if import gmsd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] sample_value;
    logic                      sample_valid;
    logic                      last_sample;

    modport source (output valid, sample_value, sample_valid, last_sample, input ready);
    modport sink (input valid, sample_value, sample_valid, last_sample, output ready);
endinterface

interface gmsd_result_if import gmsd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [STEP_W-1:0] step_doubled;
    logic                     step_valid;
    logic                     last_result;

    modport source (output valid, step_doubled, step_valid, last_result, input ready);
    modport sink (input valid, step_doubled, step_valid, last_result, output ready);
endinterface

interface gmsd_cfg_if import gmsd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/gmsd_fifo.sv
// Small item queue between the front and the back.
// Depends on gmsd_pkg.
module gmsd_fifo import gmsd_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wdata,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t rdata
);

    job_t              fifo_mem [JOB_DEPTH];
    logic [JOB_PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JOB_PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JOB_PW:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == (JOB_PW + 1)'(JOB_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = fifo_mem[rd_ptr_reg];

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fifo_mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: hw/rtl/gmsd_front.sv
// Front: settings, sample intake, ring writes and queueing of items.
// Depends on gmsd_pkg and gmsd_if.
module gmsd_front import gmsd_pkg::*; #(
    parameter int MAX_WINDOW    = 32,
    parameter int MAX_GAP       = 16,
    parameter int HISTORY_DEPTH = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    gmsd_sample_if.sink   in_ch,
    gmsd_cfg_if.sink      cfg,
    input  logic          job_full,
    output logic          job_push,
    output job_t          job_wdata,
    output ring_wr_t      ring_wr,
    output cfg_t          cfg_eff
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [WIN_W-1:0] WIN_HI = WIN_W'(MAX_WINDOW);
    localparam logic [GAP_W-1:0] GAP_HI = GAP_W'(MAX_GAP);

    logic [WIN_CFG_W-1:0] win_reg, win_next;
    logic [GAP_CFG_W-1:0] gap_reg, gap_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [SEEN_W-1:0]    seen_reg, seen_next;
    logic [WIN_W-1:0]     win_ext, win_c;
    logic [GAP_W-1:0]     gap_ext, gap_c;
    logic [SPAN_W-1:0]    span;
    logic [SEEN_W-1:0]    span_ext;
    logic                 accept;

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = !job_full;
    assign accept      = in_ch.valid && in_ch.ready;

    // Register writes
    always_comb
    begin
        win_next = win_reg;
        gap_next = gap_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_WINDOW: win_next = cfg.data[WIN_CFG_W-1:0];
                REG_GAP:    gap_next = cfg.data[GAP_CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    // Saturate settings to the supported range
    always_comb
    begin
        win_ext = WIN_W'(win_reg);
        gap_ext = GAP_W'(gap_reg);
        if (win_ext < WIN_MIN)
            win_c = WIN_MIN;
        else if (win_ext > WIN_HI)
            win_c = WIN_HI;
        else
            win_c = win_ext;
        gap_c = (gap_ext > GAP_HI) ? GAP_HI : gap_ext;
    end

    assign cfg_eff.win = win_c;
    assign cfg_eff.gap = gap_c;
    assign span        = SPAN_W'(win_c) + SPAN_W'(gap_c);
    assign span_ext    = SEEN_W'(span);

    // Item classification: one queue entry per sample
    always_comb
    begin
        job_push         = accept;
        job_wdata.newest = RING_AW_MAX'(head_reg);
        job_wdata.n      = seen_reg;
        job_wdata.fin    = in_ch.last_sample;
        job_wdata.emit   = in_ch.last_sample || (seen_reg >= span_ext);
        if (in_ch.last_sample && (seen_reg < span_ext))
            job_wdata.d = seen_reg[SPAN_W-1:0];
        else
            job_wdata.d = span;
    end

    assign ring_wr.en    = accept;
    assign ring_wr.addr  = RING_AW_MAX'(head_reg);
    assign ring_wr.ok    = in_ch.sample_valid;
    assign ring_wr.value = in_ch.sample_value;

    // Ring head and sequence index
    always_comb
    begin
        head_next = head_reg;
        seen_next = seen_reg;
        if (accept)
        begin
            head_next = head_reg + 1'b1;
            if (in_ch.last_sample)
                seen_next = '0;
            else if (seen_reg < SEEN_MAX)
                seen_next = seen_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= WIN_RESET;
            gap_reg  <= GAP_RESET;
            head_reg <= '0;
            seen_reg <= '0;
        end
        else
        begin
            win_reg  <= win_next;
            gap_reg  <= gap_next;
            head_reg <= head_next;
            seen_reg <= seen_next;
        end
    end

endmodule

// File: hw/rtl/gmsd_back.sv
// Back: history ring, insertion sorter, medians and the result register.
// Depends on gmsd_pkg and gmsd_if.
module gmsd_back import gmsd_pkg::*; #(
    parameter int MAX_WINDOW    = 32,
    parameter int HISTORY_DEPTH = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ring_wr_t      ring_wr,
    input  cfg_t          cfg_eff,
    input  logic          job_empty,
    input  job_t          job_rdata,
    output logic          job_pop,
    gmsd_result_if.source out_ch
);

    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SI_W  = $clog2(MAX_WINDOW);

    logic [MED_W-1:0] ring_mem [HISTORY_DEPTH];
    logic [MED_W-1:0] rd_q_reg;
    logic [AW-1:0]    rd_addr;

    back_state_t state_reg, state_next;
    logic                      pend_reg, pend_next;
    logic                      out_valid_reg, out_valid_next;
    logic [AW-1:0]             newest_reg, newest_next;
    logic [SEEN_W-1:0]         n_reg, n_next;
    logic [SPAN_W-1:0]         d_reg, d_next;
    logic                      fin_reg, fin_next;
    logic                      side_reg, side_next;
    logic [POS_W-1:0]          k_reg, k_next;
    logic [POS_W-1:0]          end_reg, end_next;
    logic [POS_W-1:0]          rb_reg, rb_next;
    logic [POS_W-1:0]          re_reg, re_next;
    logic [WIN_W-1:0]          minp_reg, minp_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [VALUE_W-1:0] s_reg [MAX_WINDOW];
    logic signed [VALUE_W-1:0] s_next [MAX_WINDOW];
    logic signed [VALUE_W-1:0] s_ins [MAX_WINDOW];
    logic [SI_W-1:0]           mi_reg, mi_next;
    logic signed [VALUE_W-1:0] hi_reg, hi_next;
    logic signed [MED_W-1:0]   medl_reg, medl_next;
    logic                      res_ok_reg, res_ok_next;
    logic signed [STEP_W-1:0]  res_step_reg, res_step_next;
    logic signed [STEP_W-1:0]  out_step_reg, out_step_next;
    logic                      out_ok_reg, out_ok_next;
    logic                      out_last_reg, out_last_next;

    logic [POS_W-1:0]          win_p, gap_p, n_p, i_p, le_p, lb_p, rb_p, re_full, re_p;
    logic                      bad;
    logic [WIN_W+7:0]          third_prod;
    logic [WIN_W-1:0]          third, minp;
    logic                      issue, load_done, out_free, short_cnt;
    logic signed [VALUE_W-1:0] ins_val, sel_val;
    logic                      ins_ok, do_ins;
    logic [MAX_WINDOW-1:0]     lt;
    logic signed [MED_W-1:0]   med_odd, med_even, med_cur;
    logic signed [STEP_W-1:0]  diff;

    // History ring: one write port from the front, one registered read port
    always_ff @(posedge clk)
    begin
        if (ring_wr.en)
        begin
            ring_mem[ring_wr.addr[AW-1:0]] <= {ring_wr.ok, ring_wr.value};
        end
        rd_q_reg <= ring_mem[rd_addr];
    end

    // Window bounds of the current index
    always_comb
    begin
        win_p   = POS_W'(cfg_eff.win);
        gap_p   = POS_W'(cfg_eff.gap);
        n_p     = POS_W'(n_reg);
        i_p     = n_p - POS_W'(d_reg);
        rb_p    = i_p + gap_p + 1'b1;
        bad     = (i_p <= gap_p) || (rb_p > n_p);
        le_p    = i_p - gap_p - 1'b1;
        lb_p    = ((le_p + 1'b1) > win_p) ? (le_p + 1'b1 - win_p) : '0;
        re_full = i_p + gap_p + win_p;
        re_p    = (re_full > n_p) ? n_p : re_full;
    end

    // Minimum valid count: max(3, window / 3), the division by reciprocal
    assign third_prod = (WIN_W + 8)'(cfg_eff.win) * (WIN_W + 8)'(THIRD_MUL);
    assign third      = WIN_W'(third_prod >> THIRD_SHIFT);
    assign minp       = (third < MINP_FLOOR) ? MINP_FLOOR : third;

    // Ring read address of sample k, counted from the newest slot
    assign rd_addr   = newest_reg - AW'(n_p - k_reg);
    assign issue     = (state_reg == BK_LOAD) && (k_reg <= end_reg);
    assign load_done = !issue && !pend_reg;
    assign short_cnt = (WIN_W'(cnt_reg) < minp_reg);
    assign out_free  = !out_valid_reg || out_ch.ready;

    // Insertion into the sorted row
    assign ins_val = $signed(rd_q_reg[VALUE_W-1:0]);
    assign ins_ok  = rd_q_reg[MED_W-1];
    assign do_ins  = (state_reg == BK_LOAD) && pend_reg && ins_ok;

    always_comb
    begin
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            lt[j] = (CNT_W'(j) < cnt_reg) && (s_reg[j] <= ins_val);
        end
        s_ins[0] = lt[0] ? s_reg[0] : ins_val;
        for (int j = 1; j < MAX_WINDOW; j++)
        begin
            if (lt[j])
                s_ins[j] = s_reg[j];
            else if (lt[j-1])
                s_ins[j] = ins_val;
            else
                s_ins[j] = s_reg[j-1];
        end
    end

    // Median pick: one read of the row per cycle
    assign sel_val  = s_reg[mi_reg];
    assign med_odd  = $signed({sel_val, 1'b0});
    assign med_even = $signed({hi_reg[VALUE_W-1], hi_reg})
                    + $signed({sel_val[VALUE_W-1], sel_val});
    assign med_cur  = (state_reg == BK_MED_HI) ? med_odd : med_even;
    assign diff     = $signed({med_cur[MED_W-1], med_cur})
                    - $signed({medl_reg[MED_W-1], medl_reg});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!job_empty && job_rdata.emit)
                    state_next = BK_SETUP;
            end
            BK_SETUP:
            begin
                state_next = bad ? BK_EMIT : BK_LOAD;
            end
            BK_LOAD:
            begin
                if (load_done)
                    state_next = short_cnt ? BK_EMIT : BK_MED_HI;
            end
            BK_MED_HI:
            begin
                if (!cnt_reg[0])
                    state_next = BK_MED_LO;
                else
                    state_next = side_reg ? BK_EMIT : BK_LOAD;
            end
            BK_MED_LO:
            begin
                state_next = side_reg ? BK_EMIT : BK_LOAD;
            end
            BK_EMIT:
            begin
                if (out_free)
                    state_next = (fin_reg && (d_reg != '0)) ? BK_SETUP : BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        job_pop        = 1'b0;
        pend_next      = 1'b0;
        newest_next    = newest_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        fin_next       = fin_reg;
        side_next      = side_reg;
        k_next         = k_reg;
        end_next       = end_reg;
        rb_next        = rb_reg;
        re_next        = re_reg;
        minp_next      = minp_reg;
        cnt_next       = cnt_reg;
        s_next         = s_reg;
        mi_next        = mi_reg;
        hi_next        = hi_reg;
        medl_next      = medl_reg;
        res_ok_next    = res_ok_reg;
        res_step_next  = res_step_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_step_next  = out_step_reg;
        out_ok_next    = out_ok_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop     = 1'b1;
                    newest_next = job_rdata.newest[AW-1:0];
                    n_next      = job_rdata.n;
                    d_next      = job_rdata.d;
                    fin_next    = job_rdata.fin;
                end
            end
            BK_SETUP:
            begin
                side_next     = 1'b0;
                k_next        = lb_p;
                end_next      = le_p;
                rb_next       = rb_p;
                re_next       = re_p;
                minp_next     = minp;
                cnt_next      = '0;
                res_ok_next   = 1'b0;
                res_step_next = '0;
            end
            BK_LOAD:
            begin
                pend_next = issue;
                if (issue)
                    k_next = k_reg + 1'b1;
                if (do_ins)
                begin
                    s_next   = s_ins;
                    cnt_next = cnt_reg + 1'b1;
                end
                if (load_done)
                begin
                    if (short_cnt)
                    begin
                        res_ok_next   = 1'b0;
                        res_step_next = '0;
                    end
                    else
                    begin
                        mi_next = SI_W'(cnt_reg >> 1);
                    end
                end
            end
            BK_MED_HI, BK_MED_LO:
            begin
                if ((state_reg == BK_MED_HI) && !cnt_reg[0])
                begin
                    hi_next = sel_val;
                    mi_next = mi_reg - 1'b1;
                end
                else if (!side_reg)
                begin
                    medl_next = med_cur;
                    side_next = 1'b1;
                    k_next    = rb_reg;
                    end_next  = re_reg;
                    cnt_next  = '0;
                end
                else
                begin
                    res_ok_next   = 1'b1;
                    res_step_next = diff;
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_step_next  = res_step_reg;
                    out_ok_next    = res_ok_reg;
                    out_last_next  = fin_reg && (d_reg == '0);
                    if (fin_reg && (d_reg != '0))
                        d_next = d_reg - 1'b1;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.step_doubled = out_step_reg;
    assign out_ch.step_valid   = out_ok_reg;
    assign out_ch.last_result  = out_last_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        newest_reg   <= newest_next;
        n_reg        <= n_next;
        d_reg        <= d_next;
        fin_reg      <= fin_next;
        side_reg     <= side_next;
        k_reg        <= k_next;
        end_reg      <= end_next;
        rb_reg       <= rb_next;
        re_reg       <= re_next;
        minp_reg     <= minp_next;
        cnt_reg      <= cnt_next;
        s_reg        <= s_next;
        mi_reg       <= mi_next;
        hi_reg       <= hi_next;
        medl_reg     <= medl_next;
        res_ok_reg   <= res_ok_next;
        res_step_reg <= res_step_next;
        out_step_reg <= out_step_next;
        out_ok_reg   <= out_ok_next;
        out_last_reg <= out_last_next;
    end

endmodule

// File: hw/rtl/gapped_median_step_detector.sv
// Gapped median step detector, top level. Each sample goes into a history ring and
// one queue entry; the back works entries off one at a time. For a result, both
// windows are read through the single ring read port, one sample a cycle, into an
// insertion sorter, then each median is picked in BK_MED_HI and, for an even count,
// also in BK_MED_LO. Samples that yield no result are only taken off the queue in the
// back, and an undefined step of an index too near either end goes from setup straight
// to emit. The last sample of a sequence yields up to window+gap+1 results back to back.
// Samples are taken while the four-entry queue has room; results wait in an output
// register. Depends on gmsd_pkg, gmsd_if, gmsd_front, gmsd_fifo, gmsd_back.
module gapped_median_step_detector import gmsd_pkg::*; #(
    parameter int MAX_WINDOW    = 32,
    parameter int MAX_GAP       = 16,
    parameter int HISTORY_DEPTH = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    gmsd_sample_if.sink   in_ch,
    gmsd_result_if.source out_ch,
    gmsd_cfg_if.sink      cfg
);

    logic     job_full, job_push, job_empty, job_pop;
    job_t     job_wdata, job_rdata;
    ring_wr_t ring_wr;
    cfg_t     cfg_eff;

    gmsd_front #(
        .MAX_WINDOW    (MAX_WINDOW),
        .MAX_GAP       (MAX_GAP),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg),
        .job_full  (job_full),
        .job_push  (job_push),
        .job_wdata (job_wdata),
        .ring_wr   (ring_wr),
        .cfg_eff   (cfg_eff)
    );

    gmsd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_wdata),
        .full  (job_full),
        .pop   (job_pop),
        .empty (job_empty),
        .rdata (job_rdata)
    );

    gmsd_back #(
        .MAX_WINDOW    (MAX_WINDOW),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ring_wr   (ring_wr),
        .cfg_eff   (cfg_eff),
        .job_empty (job_empty),
        .job_rdata (job_rdata),
        .job_pop   (job_pop),
        .out_ch    (out_ch)
    );

endmodule

// File: hw/rtl/gmsd_checker.sv
// Port-level checks of the step detector, bound to the top level.
// Depends on gmsd_pkg and the assertion macro header.
`include "gapped_median_step_detector_macros.svh"

module gmsd_checker import gmsd_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [STEP_W-1:0] step_doubled,
    input logic                     step_valid
);

    // A stalled result stays offered
    `GMSD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // A stalled result keeps its value
    `GMSD_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(step_doubled))

    // Undefined steps carry zero
    `GMSD_ASSERT_IMP(a_bad_zero, clk, rst_n, out_valid && !step_valid, step_doubled == '0)

    // Nothing is offered straight out of reset
    `GMSD_ASSERT_RAW(a_rst_quiet, clk, !rst_n, !out_valid)

endmodule

bind gapped_median_step_detector gmsd_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .step_doubled (out_ch.step_doubled),
    .step_valid   (out_ch.step_valid)
);

// File: bench/gmsd_tb_if.sv
`timescale 1ns / 100ps
// Marker file for the bench: the channel interfaces come from the RTL (gmsd_if.sv).
// Depends on gmsd_pkg and gmsd_if; holds the shared test item type for the bench.
package gmsd_tb_pkg;
    import gmsd_pkg::*;

    // One expected or observed result item
    typedef struct packed {
        logic signed [STEP_W-1:0] step;
        logic                     ok;
        logic                     last;
    } step_item_t;
endpackage

// File: bench/gapped_median_step_detector_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for gapped_median_step_detector: drives sample sequences and
// register writes, predicts each step result in a scoreboard, checks results in order.
// Depends on gmsd_pkg, gmsd_if (RTL) and gmsd_tb_pkg.
module gapped_median_step_detector_tb;
    import gmsd_pkg::*;
    import gmsd_tb_pkg::*;

    localparam int HIST = 128;
    localparam int WMAX = 32;
    localparam int GMAX = 16;

    // Step predictor and store of expected results
    class step_scoreboard;
        logic signed [VALUE_W-1:0] hist_val[HIST];
        bit                        hist_ok[HIST];
        int unsigned               seen;
        int unsigned               head;
        logic [WIN_CFG_W-1:0]      win_reg;
        logic [GAP_CFG_W-1:0]      gap_reg;
        step_item_t                pending[$];
        int                        mismatches;
        int                        checked;
        int                        valid_steps;

        function void clear();
            for (int k = 0; k < HIST; k++)
            begin
                hist_val[k] = '0;
                hist_ok[k]  = 0;
            end
            seen = 0;
            head = 0;
            win_reg = WIN_RESET;
            gap_reg = GAP_RESET;
            pending.delete();
            mismatches = 0;
            checked = 0;
            valid_steps = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
            if (idx == REG_WINDOW)
                win_reg = d[WIN_CFG_W-1:0];
            else
                gap_reg = d[GAP_CFG_W-1:0];
        endfunction

        // Append one expected result
        function void add_expect(step_item_t it);
            pending = {pending, it};
        endfunction

        // Doubled median of the first cnt entries
        function longint median_x2(longint vals[WMAX], int cnt);
            longint a[WMAX];
            longint t;
            int j;
            a = vals;
            for (int i = 1; i < cnt; i++)
            begin
                t = a[i];
                j = i;
                while (j > 0 && a[j-1] > t)
                begin
                    a[j] = a[j-1];
                    j--;
                end
                a[j] = t;
            end
            if (cnt % 2 == 0)
                return a[cnt/2-1] + a[cnt/2];
            return 2 * a[cnt/2];
        endfunction

        // Step for index n-d
        function step_item_t step_at(int n, int d, int win, int gap, bit fin);
            step_item_t r;
            longint lv[WMAX];
            longint rv[WMAX];
            int lc, rc, i, lb, le, rb, re, minp, pos;
            lc = 0;
            rc = 0;
            r.step = '0;
            r.ok = 0;
            r.last = fin && d == 0;
            i = n - d;
            if (i <= gap)
                return r;
            rb = i + gap + 1;
            if (rb > n)
                return r;
            re = (i + gap + win > n) ? n : i + gap + win;
            le = i - gap - 1;
            lb = (le + 1 > win) ? le + 1 - win : 0;
            for (int k = lb; k <= le; k++)
            begin
                pos = (head + HIST - 1 - ((n - k) % HIST)) % HIST;
                if (hist_ok[pos] && lc < WMAX)
                begin
                    lv[lc] = hist_val[pos];
                    lc++;
                end
            end
            for (int k = rb; k <= re; k++)
            begin
                pos = (head + HIST - 1 - ((n - k) % HIST)) % HIST;
                if (hist_ok[pos] && rc < WMAX)
                begin
                    rv[rc] = hist_val[pos];
                    rc++;
                end
            end
            minp = (win / 3 < 3) ? 3 : win / 3;
            if (lc < minp || rc < minp)
                return r;
            r.step = STEP_W'(median_x2(rv, rc) - median_x2(lv, lc));
            r.ok = 1;
            return r;
        endfunction

        // Note one accepted sample and queue its results
        function void note_sample(logic signed [VALUE_W-1:0] v, bit ok, bit fin);
            int win, gap, n, span, d;
            win = (win_reg < 3) ? 3 : (win_reg > WMAX ? WMAX : int'(win_reg));
            gap = (gap_reg > GMAX) ? GMAX : int'(gap_reg);
            hist_val[head] = v;
            hist_ok[head]  = ok;
            head = (head + 1) % HIST;
            n = seen;
            if (seen < 255)
                seen++;
            span = win + gap;
            if (!fin)
            begin
                if (n >= span)
                    add_expect(step_at(n, span, win, gap, 0));
                return;
            end
            d = (n < span) ? n : span;
            forever
            begin
                add_expect(step_at(n, d, win, gap, 1));
                if (d == 0)
                    break;
                d--;
            end
            seen = 0;
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_step(step_item_t got);
            step_item_t exp_r;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: step %0d ok %0b last %0b",
                             got.step, got.ok, got.last);
                return;
            end
            exp_r = pending.pop_front();
            if (exp_r.ok)
                valid_steps++;
            if (got !== exp_r)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp step %0d ok %0b last %0b, got %0d %0b %0b",
                             exp_r.step, exp_r.ok, exp_r.last, got.step, got.ok, got.last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   samples_sent;
    int   sequences_sent;
    bit   done_flag;

    gmsd_sample_if in_ch();
    gmsd_result_if out_ch();
    gmsd_cfg_if    cfg();

    step_scoreboard sb;

    gapped_median_step_detector dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    // Clock
    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Result sink with random stall; check on accept
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_step('{out_ch.step_doubled, out_ch.step_valid, out_ch.last_result});
        if (!rst_n)
            out_ch.ready <= 0;
        else
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Send one sample, with random idle cycles first; valid stays up afterwards
    task automatic send_sample(logic signed [VALUE_W-1:0] v, bit ok, bit fin);
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge clk);
        end
        in_ch.valid        <= 1;
        in_ch.sample_value <= v;
        in_ch.sample_valid <= ok;
        in_ch.last_sample  <= fin;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_sample(v, ok, fin);
        samples_sent++;
        if (fin)
            sequences_sent++;
    endtask

    // Wait until idle, then write a register
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
        in_ch.valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data  <= d;
        do
            @(posedge clk);
        while (!cfg.ready);
        sb.write_reg(idx, d);
        cfg.valid <= 0;
    endtask

    function automatic logic signed [VALUE_W-1:0] rand_value(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(2000)) - 1000;
            2: return 32'sh7FFFFFFF;
            default: return 32'sh80000000;
        endcase
    endfunction

    // Random sequence of len samples, mostly valid
    task automatic send_sequence(int len, int bad_pct);
        int mode;
        mode = $urandom_range(3);
        for (int k = 0; k < len; k++)
            send_sample(($urandom_range(9) == 0) ? rand_value($urandom_range(3))
                                                  : rand_value(mode > 1 ? 0 : mode),
                        $urandom_range(99) >= bad_pct, k == len - 1);
    endtask

    task automatic random_phase(int count);
        int len;
        while (count > 0)
        begin
            len = $urandom_range(1, 60);
            if ($urandom_range(19) == 0)
                len = $urandom_range(150, 300);
            if (len > count)
                len = count;
            send_sequence(len, ($urandom_range(4) == 0) ? 50 : 10);
            count -= len;
        end
    endtask

    // Main stimulus
    initial
    begin
        sb = new();
        sb.clear();
        in_ch.valid = 0;
        in_ch.sample_value = '0;
        in_ch.sample_valid = 0;
        in_ch.last_sample = 0;
        cfg.valid = 0;
        cfg.index = REG_WINDOW;
        cfg.data = '0;
        src_idle_pct = 22;
        snk_idle_pct = 63;
        samples_sent = 0;
        sequences_sent = 0;
        done_flag = 0;
        rst_n = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, invalid samples, short sequence, single sample
        send_sample(32'sh7FFFFFFF, 1, 0);
        send_sample(32'sh80000000, 1, 0);
        send_sample(0, 0, 0);
        for (int k = 0; k < 14; k++)
            send_sample((k % 2) ? 32'sh80000000 : 32'sh7FFFFFFF, k != 5, 0);
        send_sample(-1, 1, 1);
        send_sample(5, 1, 1);
        for (int k = 0; k < 6; k++)
            send_sample(k * 65536, 1, k == 5);

        // Small window, zero gap
        write_reg(REG_WINDOW, 6'd3);
        write_reg(REG_GAP, 6'd0);
        random_phase(100);
        // Out of range registers saturate
        write_reg(REG_WINDOW, 6'd63);
        write_reg(REG_GAP, 6'd31);
        src_idle_pct = 63;
        snk_idle_pct = 22;
        random_phase(130);
        write_reg(REG_WINDOW, 6'd1);
        write_reg(REG_GAP, 6'd16);
        random_phase(60);
        write_reg(REG_WINDOW, 6'd32);
        write_reg(REG_GAP, 6'd1);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_phase(80);
        write_reg(REG_WINDOW, 6'd12);
        write_reg(REG_GAP, 6'd5);
        random_phase(70);

        in_ch.valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("Sent %0d samples in %0d sequences; %0d results checked, %0d with a step.",
                 samples_sent, sequences_sent, sb.checked, sb.valid_steps);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("gapped_median_step_detector_tb: PASS");
        else
            $display("gapped_median_step_detector_tb: FAIL");
        $finish;
    end

    // Run limit
    initial
    begin
        #8000000;
        $display("gapped_median_step_detector_tb: FAIL");
        $finish;
    end
endmodule
